@@ hw/rtl/table_dpcm_audio_decoder_macros.svh @@
// Assertion macros used by the table DPCM decoder result queue.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TABLE_DPCM_AUDIO_DECODER_MACROS_SVH
`define TABLE_DPCM_AUDIO_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TDPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TDPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tdpcm_pkg.sv @@
// Shared types, step tables and constants for the table DPCM decoder.
// No dependencies; used by every module of the block.
package tdpcm_pkg;

  // Result queue depth; must be at least 2 so one byte's pair always fits
  localparam int unsigned RES_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WIDE   = 3'd0,
    CFG_STEREO = 3'd1,
    CFG_SIGNED = 3'd2,
    CFG_OLD    = 3'd3,
    CFG_CLIP   = 3'd4
  } cfg_reg_t;

  // Live configuration bits
  typedef struct packed {
    logic wide;
    logic stereo;
    logic sgn;
    logic old;
    logic clip;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [15:0] pcm;
    logic        right;
    logic        last;
  } res_t;

  localparam logic [15:0] STEP_WIDE [128] = '{
    16'h0000, 16'h0008, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060,
    16'h0070, 16'h0080, 16'h0090, 16'h00A0, 16'h00B0, 16'h00C0, 16'h00D0, 16'h00E0,
    16'h00F0, 16'h0100, 16'h0110, 16'h0120, 16'h0130, 16'h0140, 16'h0150, 16'h0160,
    16'h0170, 16'h0180, 16'h0190, 16'h01A0, 16'h01B0, 16'h01C0, 16'h01D0, 16'h01E0,
    16'h01F0, 16'h0200, 16'h0208, 16'h0210, 16'h0218, 16'h0220, 16'h0228, 16'h0230,
    16'h0238, 16'h0240, 16'h0248, 16'h0250, 16'h0258, 16'h0260, 16'h0268, 16'h0270,
    16'h0278, 16'h0280, 16'h0288, 16'h0290, 16'h0298, 16'h02A0, 16'h02A8, 16'h02B0,
    16'h02B8, 16'h02C0, 16'h02C8, 16'h02D0, 16'h02D8, 16'h02E0, 16'h02E8, 16'h02F0,
    16'h02F8, 16'h0300, 16'h0308, 16'h0310, 16'h0318, 16'h0320, 16'h0328, 16'h0330,
    16'h0338, 16'h0340, 16'h0348, 16'h0350, 16'h0358, 16'h0360, 16'h0368, 16'h0370,
    16'h0378, 16'h0380, 16'h0388, 16'h0390, 16'h0398, 16'h03A0, 16'h03A8, 16'h03B0,
    16'h03B8, 16'h03C0, 16'h03C8, 16'h03D0, 16'h03D8, 16'h03E0, 16'h03E8, 16'h03F0,
    16'h03F8, 16'h0400, 16'h0440, 16'h0480, 16'h04C0, 16'h0500, 16'h0540, 16'h0580,
    16'h05C0, 16'h0600, 16'h0640, 16'h0680, 16'h06C0, 16'h0700, 16'h0740, 16'h0780,
    16'h07C0, 16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h0C00, 16'h0D00, 16'h0E00,
    16'h0F00, 16'h1000, 16'h1400, 16'h1800, 16'h1C00, 16'h2000, 16'h3000, 16'h4000
  };

  localparam logic [7:0] STEP_NARROW [8] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h06, 8'h0A, 8'h0F, 8'h15
  };

  // Predictor start value for a sample format
  function automatic logic [31:0] start_value(input logic wide, input logic sgn);
    logic [31:0] v;
    if (sgn) begin
      v = 32'h0;
    end else if (wide) begin
      v = 32'h0000_8000;
    end else begin
      v = 32'h0000_0080;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/tdpcm_adv.sv @@
// One predictor step: table lookup, add or subtract, optional saturation,
// and the output sample coding. Depends on tdpcm_pkg.
module tdpcm_adv (
  input  tdpcm_pkg::cfg_t cfg,
  input  logic [31:0]     pred,
  input  logic [7:0]      code,
  output logic [31:0]     pred_nxt,
  output logic [15:0]     pcm
);

  logic               neg;
  logic [6:0]         idx;
  logic [15:0]        delta;
  logic [31:0]        sum;
  logic signed [31:0] lo;
  logic signed [31:0] hi;

  // Decode sign and table index; old variant complements negative indexes
  always_comb begin
    if (cfg.wide) begin
      neg = code[7];
      idx = (neg && cfg.old) ? ~code[6:0] : code[6:0];
      delta = tdpcm_pkg::STEP_WIDE[idx];
    end else begin
      neg = code[3];
      idx = {4'b0, (neg && cfg.old) ? ~code[2:0] : code[2:0]};
      delta = {8'b0, tdpcm_pkg::STEP_NARROW[idx[2:0]]};
    end
  end

  // Apply the step, wrapping at 32 bits
  assign sum = neg ? (pred - {16'b0, delta}) : (pred + {16'b0, delta});

  // Saturation bounds of the sample range
  always_comb begin
    if (cfg.wide) begin
      lo = cfg.sgn ? -32'sd32768 : 32'sd0;
      hi = cfg.sgn ? 32'sd32767 : 32'sd65535;
    end else begin
      lo = cfg.sgn ? -32'sd128 : 32'sd0;
      hi = cfg.sgn ? 32'sd127 : 32'sd255;
    end
  end

  // Clamp when clipping is on
  always_comb begin
    pred_nxt = sum;
    if (cfg.clip) begin
      if ($signed(sum) > hi) begin
        pred_nxt = hi;
      end else if ($signed(sum) < lo) begin
        pred_nxt = lo;
      end
    end
  end

  // Flip the sample's top bit on the way out for wide unsigned and narrow signed formats
  always_comb begin
    if (cfg.wide) begin
      pcm = {pred_nxt[15] ^ ~cfg.sgn, pred_nxt[14:0]};
    end else begin
      pcm = {8'b0, pred_nxt[7] ^ cfg.sgn, pred_nxt[6:0]};
    end
  end

endmodule

@@ hw/rtl/tdpcm_resq.sv @@
// Result queue: takes one or two results per cycle, hands out one per transfer.
// Depends on tdpcm_pkg and the assertion macro header.
`include "table_dpcm_audio_decoder_macros.svh"

module tdpcm_resq #(
  parameter int unsigned DEPTH = tdpcm_pkg::RES_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic             wr_two,
  input  tdpcm_pkg::res_t  wr_a,
  input  tdpcm_pkg::res_t  wr_b,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output tdpcm_pkg::res_t  out_res
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tdpcm_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   wr_ptr1;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            pop;

  // Room for a full pair, judged on the registered count
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign wr_ptr1 = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      if (wr_two) begin
        wr_ptr_nxt = (wr_ptr1 == AW'(DEPTH - 1)) ? '0 : wr_ptr1 + 1'b1;
        cnt_nxt    = cnt_nxt + CW'(2);
      end else begin
        wr_ptr_nxt = wr_ptr1;
        cnt_nxt    = cnt_nxt + CW'(1);
      end
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_nxt    = cnt_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_a;
      if (wr_two) begin
        mem_r[wr_ptr1] <= wr_b;
      end
    end
  end

  `TDPCM_ASSERT_NOW(a_cnt_max, 1'b1, cnt_r <= CW'(DEPTH), "result queue overfilled")
  `TDPCM_ASSERT_NOW(a_push_room, wr_en, room, "result push without room for a pair")
  `TDPCM_ASSERT_NEXT(a_pop_only, !wr_en && pop, cnt_r == $past(cnt_r) - CW'(1), "bad pop count")

endmodule

@@ hw/rtl/table_dpcm_audio_decoder.sv @@
// Table DPCM audio decoder top level: input register, predictor state,
// configuration registers and result queue. Depends on tdpcm_pkg, tdpcm_adv, tdpcm_resq.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------
//   input   | in_code_byte, in_chunk_end              | in_valid/in_ready
//   result  | out_pcm_sample, out_right_channel,      | out_valid/out_ready
//           | out_last_of_byte                        |
//   config  | cfg_idx, cfg_data                       | cfg_we, no wait
//
// A byte is held in the input register, decoded there in a single pass and written into
// the result queue when there is room for a pair. Wide mode sustains one byte per cycle
// while the output takes results; narrow mode yields two results per byte and is paced
// by the output. Synchronous active-low reset; no clearing pass. A stalled output fills
// the result queue, which then holds the input register and drops in_ready.
module table_dpcm_audio_decoder #(
  parameter int unsigned RES_DEPTH = tdpcm_pkg::RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic        in_chunk_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pcm_sample,
  output logic        out_right_channel,
  output logic        out_last_of_byte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic        cfg_data
);

  tdpcm_pkg::cfg_t cfg_r;
  tdpcm_pkg::cfg_t cfg_nxt;
  logic            in_vld_r;
  logic [7:0]      in_byte_r;
  logic            in_cend_r;
  logic [31:0]     left_r;
  logic [31:0]     left_nxt;
  logic [31:0]     right_r;
  logic [31:0]     right_nxt;
  logic            nir_r;
  logic            nir_nxt;
  logic            fire;
  logic            room;
  logic            go_right;
  logic [31:0]     pred_a;
  logic [7:0]      code_a;
  logic [31:0]     pred_a_nxt;
  logic [15:0]     pcm_a;
  logic [31:0]     pred_b;
  logic [31:0]     pred_b_nxt;
  logic [15:0]     pcm_b;
  logic            reload;
  tdpcm_pkg::res_t res_a;
  tdpcm_pkg::res_t res_b;
  tdpcm_pkg::res_t res_out;

  // Input register: accept whenever empty or draining this cycle
  assign fire     = in_vld_r && room;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_code_byte;
      in_cend_r <= in_chunk_end;
    end
  end

  // First step: wide byte or high nibble
  assign go_right = cfg_r.wide && cfg_r.stereo && nir_r;
  assign pred_a   = go_right ? right_r : left_r;
  assign code_a   = cfg_r.wide ? in_byte_r : {4'b0, in_byte_r[7:4]};

  tdpcm_adv u_adv_a (
    .cfg      (cfg_r),
    .pred     (pred_a),
    .code     (code_a),
    .pred_nxt (pred_a_nxt),
    .pcm      (pcm_a)
  );

  // Second step: low nibble, chained on the left predictor in mono
  assign pred_b = cfg_r.stereo ? right_r : pred_a_nxt;

  tdpcm_adv u_adv_b (
    .cfg      (cfg_r),
    .pred     (pred_b),
    .code     ({4'b0, in_byte_r[3:0]}),
    .pred_nxt (pred_b_nxt),
    .pcm      (pcm_b)
  );

  assign res_a = '{pcm: pcm_a, right: go_right, last: cfg_r.wide};
  assign res_b = '{pcm: pcm_b, right: cfg_r.stereo, last: 1'b1};

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    reload  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx)
        tdpcm_pkg::CFG_WIDE: begin
          cfg_nxt.wide = cfg_data;
          reload       = 1'b1;
        end
        tdpcm_pkg::CFG_STEREO: cfg_nxt.stereo = cfg_data;
        tdpcm_pkg::CFG_SIGNED: begin
          cfg_nxt.sgn = cfg_data;
          reload      = 1'b1;
        end
        tdpcm_pkg::CFG_OLD:    cfg_nxt.old = cfg_data;
        tdpcm_pkg::CFG_CLIP:   cfg_nxt.clip = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  // Update predictors and channel toggle
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    nir_nxt   = nir_r;
    if (reload) begin
      left_nxt  = tdpcm_pkg::start_value(cfg_nxt.wide, cfg_nxt.sgn);
      right_nxt = tdpcm_pkg::start_value(cfg_nxt.wide, cfg_nxt.sgn);
      nir_nxt   = 1'b0;
    end else if (fire) begin
      if (cfg_r.wide) begin
        if (go_right) begin
          right_nxt = pred_a_nxt;
        end else begin
          left_nxt = pred_a_nxt;
        end
        nir_nxt = cfg_r.stereo && !go_right;
      end else if (cfg_r.stereo) begin
        left_nxt  = pred_a_nxt;
        right_nxt = pred_b_nxt;
      end else begin
        left_nxt = pred_b_nxt;
      end
      if (in_cend_r) begin
        nir_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '{wide: 1'b1, stereo: 1'b0, sgn: 1'b1, old: 1'b0, clip: 1'b1};
      left_r  <= '0;
      right_r <= '0;
      nir_r   <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      nir_r   <= nir_nxt;
    end
  end

  // Result queue
  tdpcm_resq #(
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (fire),
    .wr_two    (!cfg_r.wide),
    .wr_a      (res_a),
    .wr_b      (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res_out)
  );

  assign out_pcm_sample    = res_out.pcm;
  assign out_right_channel = res_out.right;
  assign out_last_of_byte  = res_out.last;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for table_dpcm_audio_decoder: directed rows, then random phases.
// Depends on tdpcm_pkg and the decoder RTL; prediction is done locally per transfer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned BYTE_TARGET = 850;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PRINT_LIMIT = 50;
  // Indexes past the register file; writes there must do nothing
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam logic [7:0] NIBBLE_STEP [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd6, 8'd10, 8'd15, 8'd21};

  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum int {MIX_UNIFORM, MIX_RISING, MIX_FALLING, MIX_EXTREME} code_mix_t;

  // flag is chunk_end for a byte row, register value for a write row
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [7:0]  code;
    bit          flag;
    bit          typed;
    logic [15:0] pcm;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_code_byte;
  logic        in_chunk_end;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pcm_sample;
  logic        out_right_channel;
  logic        out_last_of_byte;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic        cfg_data;

  // Local copy of the decoder state and registers
  logic        m_wide = 1'b1;
  logic        m_stereo = 1'b0;
  logic        m_sgn = 1'b1;
  logic        m_old = 1'b0;
  logic        m_clip = 1'b1;
  logic [31:0] m_left = '0;
  logic [31:0] m_right = '0;
  logic        m_next_right = 1'b0;

  tdpcm_pkg::res_t pending_samples[$];
  bit          row_typed = 1'b0;
  logic [15:0] row_pcm = '0;
  bit          tx_free_run = 1'b0;
  bit          ready_now = 1'b0;
  int unsigned ready_hold = 0;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_accepted = 0;
  int unsigned narrow_bytes = 0;
  int unsigned stereo_bytes = 0;
  int unsigned samples_checked = 0;
  int unsigned sat_hits = 0;
  int unsigned reg_writes = 0;
  int unsigned format_reloads = 0;

  stim_row_t directed_rows [36] = '{
    '{ROW_BYTE, '0,                    8'h7F, 1'b0, 1'b1, 16'h4000},
    '{ROW_BYTE, '0,                    8'h7F, 1'b0, 1'b1, 16'h7FFF},
    '{ROW_BYTE, '0,                    8'hFF, 1'b0, 1'b1, 16'h3FFF},
    '{ROW_BYTE, '0,                    8'h80, 1'b0, 1'b1, 16'h3FFF},
    '{ROW_BYTE, '0,                    8'h01, 1'b1, 1'b1, 16'h4007},
    '{ROW_CFG,  tdpcm_pkg::CFG_STEREO, 8'h00, 1'b1, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h81, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h01, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h02, 1'b1, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h03, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  tdpcm_pkg::CFG_OLD,    8'h00, 1'b1, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'hFF, 1'b0, 1'b1, 16'h0008},
    '{ROW_BYTE, '0,                    8'h80, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  tdpcm_pkg::CFG_CLIP,   8'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'hC0, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  tdpcm_pkg::CFG_SIGNED, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h7F, 1'b0, 1'b1, 16'h4000},
    '{ROW_CFG,  tdpcm_pkg::CFG_CLIP,   8'h00, 1'b1, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h7F, 1'b0, 1'b1, 16'h4000},
    '{ROW_CFG,  tdpcm_pkg::CFG_WIDE,   8'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h77, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h88, 1'b1, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'hF0, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  tdpcm_pkg::CFG_OLD,    8'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h8F, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  tdpcm_pkg::CFG_SIGNED, 8'h00, 1'b1, 1'b0, 16'h0000},
    '{ROW_CFG,  tdpcm_pkg::CFG_STEREO, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h77, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h77, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h77, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h77, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'hFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'hFF, 1'b1, 1'b0, 16'h0000},
    '{ROW_CFG,  CFG_SPARE_LO,          8'h00, 1'b1, 1'b0, 16'h0000},
    '{ROW_CFG,  CFG_SPARE_HI,          8'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTE, '0,                    8'h77, 1'b0, 1'b0, 16'h0000}
  };

  table_dpcm_audio_decoder dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Step size of the 128-entry wide table, rebuilt from its piecewise slopes
  function automatic logic [31:0] wide_step(logic [6:0] k);
    int unsigned n;
    n = {25'b0, k};
    if (n == 0) return 32'h0;
    else if (n == 1) return 32'h8;
    else if (n <= 33) return (n - 1) * 32'h10;
    else if (n <= 97) return 32'h200 + (n - 33) * 32'h8;
    else if (n <= 113) return 32'h400 + (n - 97) * 32'h40;
    else if (n <= 121) return 32'h800 + (n - 113) * 32'h100;
    else if (n <= 125) return 32'h1000 + (n - 121) * 32'h400;
    else return 32'h2000 + (n - 125) * 32'h1000;
  endfunction

  // Apply one code to a predictor; narrow codes sit in the low nibble
  function automatic logic [31:0] advance_pred(logic [31:0] p, logic [7:0] code);
    logic        neg;
    logic [6:0]  k;
    logic [31:0] d;
    longint      v, lo, hi, half, clamped;
    if (m_wide) begin
      neg = code[7];
      k = (neg && m_old) ? ~code[6:0] : code[6:0];
      d = wide_step(k);
    end else begin
      neg = code[3];
      k = {4'h0, (neg && m_old) ? ~code[2:0] : code[2:0]};
      d = {24'h0, NIBBLE_STEP[k[2:0]]};
    end
    p = neg ? p - d : p + d;
    if (m_clip) begin
      v = longint'($signed(p));
      half = m_wide ? 32768 : 128;
      lo = m_sgn ? -half : 0;
      hi = m_sgn ? half - 1 : 2 * half - 1;
      clamped = (v > hi) ? hi : ((v < lo) ? lo : v);
      if (clamped != v) sat_hits++;
      p = clamped[31:0];
    end
    return p;
  endfunction

  function automatic logic [15:0] to_pcm(logic [31:0] p);
    if (m_wide) return p[15:0] ^ (m_sgn ? 16'h0000 : 16'h8000);
    return {8'h00, p[7:0] ^ (m_sgn ? 8'h80 : 8'h00)};
  endfunction

  // Register write; a format change reloads both predictors
  function automatic void apply_cfg(logic [2:0] idx, logic val);
    bit reload;
    reload = 1'b0;
    reg_writes++;
    case (idx)
      tdpcm_pkg::CFG_WIDE: begin
        m_wide = val;
        reload = 1'b1;
      end
      tdpcm_pkg::CFG_STEREO: m_stereo = val;
      tdpcm_pkg::CFG_SIGNED: begin
        m_sgn = val;
        reload = 1'b1;
      end
      tdpcm_pkg::CFG_OLD: m_old = val;
      tdpcm_pkg::CFG_CLIP: m_clip = val;
      default: ;
    endcase
    if (reload) begin
      m_left = m_sgn ? 32'h0 : (m_wide ? 32'h8000 : 32'h80);
      m_right = m_left;
      m_next_right = 1'b0;
      format_reloads++;
    end
  endfunction

  // Decode one accepted byte and queue the samples it yields
  function automatic void decode_byte(logic [7:0] code, logic cend);
    tdpcm_pkg::res_t r;
    logic rch;
    bytes_accepted++;
    if (m_stereo) stereo_bytes++;
    if (m_wide) begin
      rch = m_stereo & m_next_right;
      if (rch) begin
        m_right = advance_pred(m_right, code);
        r.pcm = to_pcm(m_right);
      end else begin
        m_left = advance_pred(m_left, code);
        r.pcm = to_pcm(m_left);
      end
      if (row_typed) r.pcm = row_pcm;
      r.right = rch;
      r.last = 1'b1;
      pending_samples.push_back(r);
      m_next_right = m_stereo & ~rch;
    end else begin
      narrow_bytes++;
      m_left = advance_pred(m_left, {4'h0, code[7:4]});
      r.pcm = to_pcm(m_left);
      r.right = 1'b0;
      r.last = 1'b0;
      pending_samples.push_back(r);
      if (m_stereo) begin
        m_right = advance_pred(m_right, {4'h0, code[3:0]});
        r.pcm = to_pcm(m_right);
        r.right = 1'b1;
      end else begin
        m_left = advance_pred(m_left, {4'h0, code[3:0]});
        r.pcm = to_pcm(m_left);
      end
      r.last = 1'b1;
      pending_samples.push_back(r);
    end
    if (cend) m_next_right = 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] %s mismatch on sample %0d: got %h, want %h",
               $realtime, what, samples_checked, got, want);
  endtask

  // Track register writes and input transfers, check result transfers
  always @(posedge clk) begin
    tdpcm_pkg::res_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles,
               pending_samples.size());
      $display("simulation failed");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) apply_cfg(cfg_idx, cfg_data);
      if (in_valid && in_ready) decode_byte(in_code_byte, in_chunk_end);
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected sample", out_pcm_sample, 16'h0000);
        end else begin
          want = pending_samples.pop_front();
          if (out_pcm_sample !== want.pcm)
            report_mismatch("pcm_sample", out_pcm_sample, want.pcm);
          if (out_right_channel !== want.right)
            report_mismatch("right_channel", {15'h0, out_right_channel}, {15'h0, want.right});
          if (out_last_of_byte !== want.last)
            report_mismatch("last_of_byte", {15'h0, out_last_of_byte}, {15'h0, want.last});
          samples_checked++;
        end
      end
    end
  end

  // Result side back-pressure: short stalls and open stretches, some long stalls, some long open stretches
  always @(negedge clk) begin
    int unsigned r;
    if (ready_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        ready_now = 1'b1;
        ready_hold = $urandom_range(1, 8);
      end else if (r < 85) begin
        ready_now = 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else if (r < 95) begin
        ready_now = 1'b0;
        ready_hold = $urandom_range(10, 60);
      end else begin
        ready_now = 1'b1;
        ready_hold = $urandom_range(100, 300);
      end
    end
    ready_hold--;
    out_ready <= ready_now;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_free_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_code(code_mix_t mix);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case (mix)
      MIX_RISING: if ($urandom_range(0, 99) < 85) b = b & 8'h77;
      MIX_FALLING: if ($urandom_range(0, 99) < 85) b = b | 8'h88;
      MIX_EXTREME: b = ($urandom_range(0, 4) == 0) ? (b & 8'h88) : (b | 8'h77);
      default: ;
    endcase
    return b;
  endfunction

  // Called on a falling edge; returns on a falling edge
  task automatic write_reg(logic [2:0] idx, bit val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold off the input until every queued sample has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic send_byte(logic [7:0] code, bit cend, bit typed, logic [15:0] pcm);
    int unsigned gap;
    in_valid <= 1'b1;
    in_code_byte <= code;
    in_chunk_end <= cend;
    row_typed = typed;
    row_pcm = pcm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int unsigned n_items, pause_at, phase;
    code_mix_t   mix;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_code_byte = '0;
    in_chunk_end = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: extremes, both formats and channel modes, spare indexes
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[k].idx, directed_rows[k].flag);
      end else begin
        send_byte(directed_rows[k].code, directed_rows[k].flag, directed_rows[k].typed,
                  directed_rows[k].pcm);
      end
    end

    // Random phases: new settings on an idle block, then a run of uniform or biased codes
    phase = 0;
    while (bytes_accepted < BYTE_TARGET) begin
      wait_drained();
      if ($urandom_range(0, 2) != 0)
        write_reg(tdpcm_pkg::CFG_WIDE, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tdpcm_pkg::CFG_STEREO, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tdpcm_pkg::CFG_SIGNED, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tdpcm_pkg::CFG_OLD, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tdpcm_pkg::CFG_CLIP, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0)
        write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 1'($urandom_range(0, 1)));
      mix = code_mix_t'($urandom_range(0, 3));
      n_items = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 200) : $urandom_range(8, 60);
      // Trim the last phase so the total lands on the target
      if (n_items > BYTE_TARGET - bytes_accepted) n_items = BYTE_TARGET - bytes_accepted;
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n_items - 1)
                                                           : n_items;
      tx_free_run = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) wait_drained();
        send_byte(pick_code(mix), $urandom_range(0, 7) == 0, 1'b0, 16'h0000);
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("decoded %0d bytes (%0d narrow, %0d stereo) across %0d phases, %0d reg writes",
             bytes_accepted, narrow_bytes, stereo_bytes, phase, reg_writes);
    $display("checked %0d samples, %0d format reloads, %0d saturating steps, %0d mismatches",
             samples_checked, format_reloads, sat_hits, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tdpcm_pkg.sv
hw/rtl/tdpcm_adv.sv
hw/rtl/tdpcm_resq.sv
hw/rtl/table_dpcm_audio_decoder.sv
sim/tb.sv
